### hdl/msps_pkg.sv
// Shared types, function codes and sort-key helpers for the Minkowski sum core.
// No dependencies; imported by every module in hdl/.
`default_nettype none

package msps_pkg;

   localparam int CoordW = 16;
   localparam int SumW   = CoordW + 1;
   localparam int KeyW   = 2 * SumW;

   localparam logic [1:0] FuncLoadA   = 2'd0;
   localparam logic [1:0] FuncLoadB   = 2'd1;
   localparam logic [1:0] FuncCompute = 2'd2;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [SumW-1:0]   sum_type;
   typedef logic [KeyW-1:0]          key_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic clear;
   } store_ctrl_type;

   // Sign bits flipped so an unsigned compare orders by signed x, then signed y.
   function automatic key_type make_key(sum_type sx, sum_type sy);
      return {~sx[SumW-1], sx[SumW-2:0], ~sy[SumW-1], sy[SumW-2:0]};
   endfunction

   function automatic sum_type key_x(key_type k);
      return {~k[KeyW-1], k[KeyW-2:SumW]};
   endfunction

   function automatic sum_type key_y(key_type k);
      return {~k[SumW-1], k[SumW-2:0]};
   endfunction

endpackage

`default_nettype wire

### hdl/msps_pt_store.sv
// Point storage for sets A and B, fill counts and the dropped-point flag.
// Depends on msps_pkg.
`default_nettype none

module msps_pt_store #(
   parameter int MAX_POINTS = 8,
   parameter int IDX_W      = 3,
   parameter int CNT_W      = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire msps_pkg::store_ctrl_type ctrl,
   input  wire msps_pkg::coord_type      wr_x,
   input  wire msps_pkg::coord_type      wr_y,
   input  wire logic [IDX_W-1:0]         rd_a_idx,
   input  wire logic [IDX_W-1:0]         rd_b_idx,
   output msps_pkg::coord_type           rd_a_x,
   output msps_pkg::coord_type           rd_a_y,
   output msps_pkg::coord_type           rd_b_x,
   output msps_pkg::coord_type           rd_b_y,
   output logic [CNT_W-1:0]              cnt_a,
   output logic [CNT_W-1:0]              cnt_b,
   output logic                          dropped
);
   import msps_pkg::*;

   coord_type ax_ff [MAX_POINTS];
   coord_type ay_ff [MAX_POINTS];
   coord_type bx_ff [MAX_POINTS];
   coord_type by_ff [MAX_POINTS];

   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0] cnt_b_ff, cnt_b_in;
   logic             dropped_ff, dropped_in;
   logic             a_full, b_full;
   logic             wr_a, wr_b;

   assign a_full = (cnt_a_ff >= CNT_W'(MAX_POINTS));
   assign b_full = (cnt_b_ff >= CNT_W'(MAX_POINTS));
   assign wr_a   = ctrl.load_a && !a_full;
   assign wr_b   = ctrl.load_b && !b_full;

   always_comb begin
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      dropped_in = dropped_ff;
      priority if (ctrl.clear) begin
         cnt_a_in   = '0;
         cnt_b_in   = '0;
         dropped_in = 1'b0;
      end else if (ctrl.load_a) begin
         if (a_full) begin
            dropped_in = 1'b1;
         end else begin
            cnt_a_in = cnt_a_ff + CNT_W'(1);
         end
      end else if (ctrl.load_b) begin
         if (b_full) begin
            dropped_in = 1'b1;
         end else begin
            cnt_b_in = cnt_b_ff + CNT_W'(1);
         end
      end else ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff   <= '0;
         cnt_b_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         cnt_a_ff   <= cnt_a_in;
         cnt_b_ff   <= cnt_b_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         ax_ff[cnt_a_ff[IDX_W-1:0]] <= wr_x;
         ay_ff[cnt_a_ff[IDX_W-1:0]] <= wr_y;
      end
      if (wr_b) begin
         bx_ff[cnt_b_ff[IDX_W-1:0]] <= wr_x;
         by_ff[cnt_b_ff[IDX_W-1:0]] <= wr_y;
      end
   end

   assign rd_a_x  = ax_ff[rd_a_idx];
   assign rd_a_y  = ay_ff[rd_a_idx];
   assign rd_b_x  = bx_ff[rd_b_idx];
   assign rd_b_y  = by_ff[rd_b_idx];
   assign cnt_a   = cnt_a_ff;
   assign cnt_b   = cnt_b_ff;
   assign dropped = dropped_ff;

endmodule

`default_nettype wire

### hdl/msps_sum_unit.sv
// Shared pair adder and key comparator: forms a+b and decides whether it is
// the best candidate above the previous emitted sum. Depends on msps_pkg.
`default_nettype none

module msps_sum_unit (
   input  wire msps_pkg::coord_type a_x,
   input  wire msps_pkg::coord_type a_y,
   input  wire msps_pkg::coord_type b_x,
   input  wire msps_pkg::coord_type b_y,
   input  wire msps_pkg::key_type   prev_key,
   input  wire logic                have_prev,
   input  wire msps_pkg::key_type   best_key,
   input  wire logic                have_best,
   output msps_pkg::key_type        sum_key,
   output logic                     take
);
   import msps_pkg::*;

   sum_type sx, sy;

   assign sx      = sum_type'(a_x) + sum_type'(b_x);
   assign sy      = sum_type'(a_y) + sum_type'(b_y);
   assign sum_key = make_key(sx, sy);
   assign take    = (!have_prev || (sum_key > prev_key)) &&
                    (!have_best || (sum_key < best_key));

endmodule

`default_nettype wire

### hdl/msps_seq.sv
// Sequencer: request decode, pair scan counters, candidate registers and
// the result output register. Depends on msps_pkg.
`default_nettype none

module msps_seq #(
   parameter int IDX_W = 3,
   parameter int CNT_W = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_func,
   input  wire logic [CNT_W-1:0]    cnt_a,
   input  wire logic [CNT_W-1:0]    cnt_b,
   input  wire logic                dropped,
   output msps_pkg::store_ctrl_type ctrl,
   output logic [IDX_W-1:0]         a_idx,
   output logic [IDX_W-1:0]         b_idx,
   input  wire msps_pkg::key_type   sum_key,
   input  wire logic                take,
   output msps_pkg::key_type        prev_key,
   output logic                     have_prev,
   output msps_pkg::key_type        best_key,
   output logic                     have_best,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output msps_pkg::sum_type        rsp_sum_x,
   output msps_pkg::sum_type        rsp_sum_y,
   output logic                     rsp_valid_res,
   output logic                     rsp_last,
   output logic                     rsp_overflow
);
   import msps_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] a_idx_ff, a_idx_in;
   logic [IDX_W-1:0] b_idx_ff, b_idx_in;
   key_type          prev_ff, prev_in;
   key_type          best_ff, best_in;
   logic             have_prev_ff, have_prev_in;
   logic             have_best_ff, have_best_in;

   logic             rsp_valid_ff, rsp_valid_in;
   sum_type          rsp_x_ff, rsp_x_in;
   sum_type          rsp_y_ff, rsp_y_in;
   logic             rsp_vres_ff, rsp_vres_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             out_free, accept;
   logic [IDX_W-1:0] last_a, last_b;
   logic             a_wrap, end_pair;
   key_type          best_nx;
   logic             found_nx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign last_a   = IDX_W'(cnt_a - CNT_W'(1));
   assign last_b   = IDX_W'(cnt_b - CNT_W'(1));
   assign a_wrap   = (a_idx_ff == last_a);
   assign end_pair = a_wrap && (b_idx_ff == last_b);
   assign best_nx  = take ? sum_key : best_ff;
   assign found_nx = have_best_ff || take;

   always_comb begin
      state_in     = state_ff;
      a_idx_in     = a_idx_ff;
      b_idx_in     = b_idx_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      have_prev_in = have_prev_ff;
      have_best_in = have_best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_vres_in  = rsp_vres_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FuncLoadA: ctrl.load_a = 1'b1;
                  FuncLoadB: ctrl.load_b = 1'b1;
                  FuncCompute: begin
                     if ((cnt_a == '0) || (cnt_b == '0)) begin
                        rsp_valid_in = 1'b1;
                        rsp_x_in     = '0;
                        rsp_y_in     = '0;
                        rsp_vres_in  = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_ovf_in   = dropped;
                        ctrl.clear   = 1'b1;
                     end else begin
                        state_in     = ST_SCAN;
                        a_idx_in     = '0;
                        b_idx_in     = '0;
                        have_prev_in = 1'b0;
                        have_best_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            priority if (!end_pair) begin
               best_in      = best_nx;
               have_best_in = found_nx;
               if (a_wrap) begin
                  a_idx_in = '0;
                  b_idx_in = b_idx_ff + IDX_W'(1);
               end else begin
                  a_idx_in = a_idx_ff + IDX_W'(1);
               end
            end else if (!have_prev_ff) begin
               prev_in      = best_nx;
               have_prev_in = 1'b1;
               have_best_in = 1'b0;
               a_idx_in     = '0;
               b_idx_in     = '0;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = key_x(prev_ff);
               rsp_y_in     = key_y(prev_ff);
               rsp_vres_in  = 1'b1;
               rsp_last_in  = !found_nx;
               rsp_ovf_in   = dropped;
               if (found_nx) begin
                  prev_in      = best_nx;
                  have_best_in = 1'b0;
                  a_idx_in     = '0;
                  b_idx_in     = '0;
               end else begin
                  ctrl.clear = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         a_idx_ff     <= '0;
         b_idx_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
         have_best_ff <= have_best_in;
         a_idx_ff     <= a_idx_in;
         b_idx_ff     <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_vres_ff <= rsp_vres_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign a_idx         = a_idx_ff;
   assign b_idx         = b_idx_ff;
   assign prev_key      = prev_ff;
   assign have_prev     = have_prev_ff;
   assign best_key      = best_ff;
   assign have_best     = have_best_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_x     = rsp_x_ff;
   assign rsp_sum_y     = rsp_y_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

`default_nettype wire

### hdl/minkowski_sum_point_sets_core.sv
// Minkowski sum of two point sets: top level.
// Depends on msps_pkg, msps_pt_store, msps_sum_unit and msps_seq.
//
// Load transactions (func 0 for set A, 1 for set B) give no result; a point
// beyond MAX_POINTS is dropped and sets the overflow flag. A compute
// transaction (func 2) emits the distinct sums a+b in ascending order of x,
// then y, the final one marked rsp_last, and then empties both sets and
// clears the flag. If either set is empty it emits one transaction with
// rsp_valid_res low. Compute finds each result by scanning all
// P = |A|*|B| pairs through one shared adder/comparator, one pair per cycle,
// holding at the end of a scan while the output register is full.
// req_ready is low during a compute and while a result waits in the output
// register.
`default_nettype none

module minkowski_sum_point_sets_core #(
   parameter int MAX_POINTS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_func,
   input  wire msps_pkg::coord_type req_x,
   input  wire msps_pkg::coord_type req_y,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output msps_pkg::sum_type        rsp_sum_x,
   output msps_pkg::sum_type        rsp_sum_y,
   output logic                     rsp_valid_res,
   output logic                     rsp_last,
   output logic                     rsp_overflow
);
   import msps_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   store_ctrl_type   ctrl;
   logic [IDX_W-1:0] a_idx, b_idx;
   coord_type        a_x, a_y, b_x, b_y;
   logic [CNT_W-1:0] cnt_a, cnt_b;
   logic             dropped;
   key_type          sum_key, prev_key, best_key;
   logic             take, have_prev, have_best;

   msps_pt_store #(
      .MAX_POINTS (MAX_POINTS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .wr_x     (req_x),
      .wr_y     (req_y),
      .rd_a_idx (a_idx),
      .rd_b_idx (b_idx),
      .rd_a_x   (a_x),
      .rd_a_y   (a_y),
      .rd_b_x   (b_x),
      .rd_b_y   (b_y),
      .cnt_a    (cnt_a),
      .cnt_b    (cnt_b),
      .dropped  (dropped)
   );

   msps_sum_unit u_sum (
      .a_x       (a_x),
      .a_y       (a_y),
      .b_x       (b_x),
      .b_y       (b_y),
      .prev_key  (prev_key),
      .have_prev (have_prev),
      .best_key  (best_key),
      .have_best (have_best),
      .sum_key   (sum_key),
      .take      (take)
   );

   msps_seq #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .cnt_a         (cnt_a),
      .cnt_b         (cnt_b),
      .dropped       (dropped),
      .ctrl          (ctrl),
      .a_idx         (a_idx),
      .b_idx         (b_idx),
      .sum_key       (sum_key),
      .take          (take),
      .prev_key      (prev_key),
      .have_prev     (have_prev),
      .best_key      (best_key),
      .have_best     (have_best),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_x     (rsp_sum_x),
      .rsp_sum_y     (rsp_sum_y),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire
